/* hdl/jtp_pkg.sv */
`default_nettype none

package jtp_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_t;

    typedef struct packed {
        logic invalid_seen;
        logic message_done;
    } flag_t;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_WORD   = 2'd1,
        MODE_STRING = 2'd2
    } scan_mode_t;

    localparam int KW_COUNT = 3;

    // keyword order in the match flags: true, false, null
    localparam logic [1:0] KW_TRUE  = 2'd0;
    localparam logic [1:0] KW_FALSE = 2'd1;
    localparam logic [1:0] KW_NULL  = 2'd2;

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd4, 3'd5, 3'd4};
    localparam logic [2:0] POS_MAX   = 3'd7;
    localparam logic [2:0] MATCH_ALL = 3'b111;

    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHR_QUOTE   = 8'h22;
    localparam logic [7:0] CHR_BSLASH  = 8'h5C;
    localparam logic [7:0] CHR_COMMA   = 8'h2C;
    localparam logic [7:0] CHR_COLON   = 8'h3A;
    localparam logic [7:0] CHR_LBRACE  = 8'h7B;
    localparam logic [7:0] CHR_RBRACE  = 8'h7D;
    localparam logic [7:0] CHR_LBRACK  = 8'h5B;
    localparam logic [7:0] CHR_RBRACK  = 8'h5D;
    localparam logic [7:0] CHR_DOT     = 8'h2E;
    localparam logic [7:0] CHR_MINUS   = 8'h2D;
    localparam logic [7:0] CHR_PLUS    = 8'h2B;
    localparam logic [7:0] CHR_LOWER_E = 8'h65;
    localparam logic [7:0] CHR_UPPER_E = 8'h45;

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= CHR_LOWER_A) && (c <= CHR_LOWER_Z);
    endfunction

    function automatic logic is_allowed(input logic [7:0] c);
        logic ok;
        ok = (c >= CHR_DIGIT_0) && (c <= CHR_DIGIT_9);
        case (c)
            CHR_COMMA, CHR_COLON, CHR_LBRACE, CHR_RBRACE, CHR_LBRACK, CHR_RBRACK,
            CHR_DOT, CHR_MINUS, CHR_PLUS, CHR_LOWER_E, CHR_UPPER_E: ok = 1'b1;
            default: ;
        endcase
        return ok;
    endfunction

    // Letter of a keyword at a position; zero past the keyword's end.
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (k)
            KW_TRUE: begin
                case (pos)
                    3'd0:    ch = "t";
                    3'd1:    ch = "r";
                    3'd2:    ch = "u";
                    3'd3:    ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            KW_FALSE: begin
                case (pos)
                    3'd0:    ch = "f";
                    3'd1:    ch = "a";
                    3'd2:    ch = "l";
                    3'd3:    ch = "s";
                    3'd4:    ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            KW_NULL: begin
                case (pos)
                    3'd0:    ch = "n";
                    3'd1:    ch = "u";
                    3'd2:    ch = "l";
                    3'd3:    ch = "l";
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Drop every keyword whose letter at pos differs from c; a keyword already past its end is kept.
    function automatic logic [2:0] letter_match(input logic [2:0] flags,
                                                input logic [2:0] pos,
                                                input logic [7:0] c);
        logic [2:0] f;
        f = flags;
        for (int k = 0; k < KW_COUNT; k++) begin
            if ((pos < KW_LEN[k]) && (kw_char(2'(k), pos) != c)) begin
                f[k] = 1'b0;
            end
        end
        return f;
    endfunction

    function automatic logic word_ok(input logic [2:0] flags, input logic [2:0] pos);
        logic ok;
        ok = 1'b0;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (flags[k] && (pos >= KW_LEN[k])) begin
                ok = 1'b1;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

/* hdl/jtp_scan_core.sv */
`default_nettype none

module jtp_scan_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  wire jtp_pkg::char_t cur,
    output jtp_pkg::flag_t     result
);
    import jtp_pkg::*;

    scan_mode_t mode_reg, mode_next;
    logic       skip_reg, skip_next;
    logic [2:0] pos_reg, pos_next;
    logic [2:0] match_reg, match_next;
    logic       error_reg, error_next;

    scan_mode_t mode_calc;
    logic       skip_calc;
    logic [2:0] pos_calc;
    logic [2:0] match_calc;
    logic       error_calc;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg  <= MODE_NORMAL;
            skip_reg  <= 1'b0;
            pos_reg   <= 3'd0;
            match_reg <= MATCH_ALL;
            error_reg <= 1'b0;
        end else if (advance) begin
            mode_reg  <= mode_next;
            skip_reg  <= skip_next;
            pos_reg   <= pos_next;
            match_reg <= match_next;
            error_reg <= error_next;
        end
    end

    always_comb begin
        mode_calc  = mode_reg;
        skip_calc  = skip_reg;
        pos_calc   = pos_reg;
        match_calc = match_reg;
        error_calc = error_reg;

        case (mode_reg)
            MODE_WORD: begin
                if (is_lower(cur.char_code)) begin
                    match_calc = letter_match(match_reg, pos_reg, cur.char_code);
                    pos_calc   = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 3'd1;
                end else begin
                    // terminator is consumed without classification
                    if (!word_ok(match_reg, pos_reg)) begin
                        error_calc = 1'b1;
                    end
                    mode_calc = MODE_NORMAL;
                end
            end
            MODE_STRING: begin
                if (skip_reg) begin
                    skip_calc = 1'b0;
                end else if (cur.char_code == CHR_BSLASH) begin
                    skip_calc = 1'b1;
                end else if (cur.char_code == CHR_QUOTE) begin
                    mode_calc = MODE_NORMAL;
                end
            end
            default: begin
                mode_calc = MODE_NORMAL;
                if (is_lower(cur.char_code)) begin
                    mode_calc  = MODE_WORD;
                    match_calc = letter_match(MATCH_ALL, 3'd0, cur.char_code);
                    pos_calc   = 3'd1;
                end else if (cur.char_code == CHR_QUOTE) begin
                    mode_calc = MODE_STRING;
                    skip_calc = 1'b0;
                end else if (!is_allowed(cur.char_code)) begin
                    error_calc = 1'b1;
                end
            end
        endcase

        result.invalid_seen = error_calc;
        result.message_done = cur.last_char;

        // start the next message from a clean scanner
        if (cur.last_char) begin
            mode_next  = MODE_NORMAL;
            skip_next  = 1'b0;
            pos_next   = 3'd0;
            match_next = MATCH_ALL;
            error_next = 1'b0;
        end else begin
            mode_next  = mode_calc;
            skip_next  = skip_calc;
            pos_next   = pos_calc;
            match_next = match_calc;
            error_next = error_calc;
        end
    end

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        advance && error_reg && !cur.last_char |=> error_reg)
        else $error("error flag dropped inside a message");

    a_clean_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && cur.last_char |=> mode_reg == MODE_NORMAL && !error_reg && !skip_reg
            && match_reg == MATCH_ALL && pos_reg == 3'd0)
        else $error("scanner not cleared after final byte");

    a_skip_in_string: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg |-> mode_reg == MODE_STRING)
        else $error("escape pending outside a string");

endmodule

`default_nettype wire

/* hdl/json_text_prevalidator.sv */
// Channel | Signals                              | Moves
// char    | char_valid, char_ready, char_data    | one byte request in (code, last flag)
// flag    | flag_valid, flag_ready, flag_data    | one result out (invalid_seen, message_done)
//
// One byte is taken per cycle while the flag side keeps up; its result passes through
// the input register, then the result register, which captures the combinational scanner update.
// Reset clears the scanner to normal mode with no error and empties both registers.
// A stalled flag side holds the result; the input register still fills, then
// char_ready drops until the result is taken.
`default_nettype none

module json_text_prevalidator (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           char_valid,
    output logic                char_ready,
    input  wire jtp_pkg::char_t char_data,
    output logic                flag_valid,
    input  wire logic           flag_ready,
    output jtp_pkg::flag_t      flag_data
);
    import jtp_pkg::*;

    logic  char_valid_reg;
    char_t char_data_reg;
    logic  flag_valid_reg;
    flag_t flag_data_reg;
    flag_t scan_result;
    logic  advance;

    // move the held request into the result slot when it is free or draining
    assign advance    = char_valid_reg && (!flag_valid_reg || flag_ready);
    assign char_ready = !char_valid_reg || advance;
    assign flag_valid = flag_valid_reg;
    assign flag_data  = flag_data_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            char_valid_reg <= 1'b0;
            flag_valid_reg <= 1'b0;
        end else begin
            if (char_ready) begin
                char_valid_reg <= char_valid;
            end
            if (advance) begin
                flag_valid_reg <= 1'b1;
            end else if (flag_ready) begin
                flag_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (char_ready && char_valid) begin
            char_data_reg <= char_data;
        end
        if (advance) begin
            flag_data_reg <= scan_result;
        end
    end

    jtp_scan_core u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cur     (char_data_reg),
        .result  (scan_result)
    );

endmodule

`default_nettype wire

/* tb/json_text_prevalidator_test.sv */
`timescale 1ns / 100ps

module json_text_prevalidator_test;

    import jtp_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   char_valid = 1'b0;
    logic   char_ready;
    char_t  char_data = '0;
    logic   flag_valid;
    logic   flag_ready = 1'b0;
    flag_t  flag_data;

    // scanner copy used to predict each flag
    scan_mode_t mode;
    logic       skip_esc;
    logic [2:0] letters;
    logic [2:0] kw_alive;
    logic       err_sticky;

    string kw_words[3] = '{"true", "false", "null"};

    flag_t pending_flags[$];
    int    flag_mismatches = 0;
    int    cycle_count = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    bit    hold_start = 1'b0;
    int    hold_left = 0;

    json_text_prevalidator i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data),
        .flag_valid (flag_valid),
        .flag_ready (flag_ready),
        .flag_data  (flag_data)
    );

    always #5 clk = ~clk;

    function automatic void clear_scanner();
        mode = MODE_NORMAL;
        skip_esc = 1'b0;
        letters = 3'd0;
        kw_alive = 3'b111;
        err_sticky = 1'b0;
    endfunction

    function automatic void take_letter(input logic [7:0] c);
        for (int k = 0; k < 3; k++)
        begin
            if (letters < kw_words[k].len() && kw_words[k][letters] != c)
                kw_alive[k] = 1'b0;
        end
        if (letters != 3'd7)
            letters = letters + 3'd1;
    endfunction

    function automatic flag_t scan_char(input char_t item);
        logic [7:0] c;
        logic       word_pass;
        flag_t      res;
        c = item.char_code;
        case (mode)
            MODE_WORD:
            begin
                if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z)
                    take_letter(c);
                else
                begin
                    word_pass = 1'b0;
                    for (int k = 0; k < 3; k++)
                    begin
                        if (kw_alive[k] && letters >= kw_words[k].len())
                            word_pass = 1'b1;
                    end
                    if (!word_pass)
                        err_sticky = 1'b1;
                    // terminator is consumed here, not classified
                    mode = MODE_NORMAL;
                end
            end
            MODE_STRING:
            begin
                if (skip_esc)
                    skip_esc = 1'b0;
                else if (c == CHR_BSLASH)
                    skip_esc = 1'b1;
                else if (c == CHR_QUOTE)
                    mode = MODE_NORMAL;
            end
            default:
            begin
                mode = MODE_NORMAL;
                if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z)
                begin
                    mode = MODE_WORD;
                    letters = 3'd0;
                    kw_alive = 3'b111;
                    take_letter(c);
                end
                else if (c == CHR_QUOTE)
                begin
                    mode = MODE_STRING;
                    skip_esc = 1'b0;
                end
                else
                begin
                    case (c)
                        CHR_COMMA, CHR_COLON, CHR_LBRACE, CHR_RBRACE, CHR_LBRACK,
                        CHR_RBRACK, CHR_DOT, CHR_MINUS, CHR_PLUS, CHR_LOWER_E,
                        CHR_UPPER_E: ;
                        default:
                            if (c < CHR_DIGIT_0 || c > CHR_DIGIT_9)
                                err_sticky = 1'b1;
                    endcase
                end
            end
        endcase
        res.invalid_seen = err_sticky;
        res.message_done = item.last_char;
        if (item.last_char)
            clear_scanner();
        return res;
    endfunction

    // Offer one request, hold it until taken, then predict its flag.
    task automatic send_char(input char_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_data <= item;
        @(posedge clk);
        while (!char_ready)
            @(posedge clk);
        pending_flags.push_back(scan_char(item));
    endtask

    task automatic send_message(input byte_q_t msg);
        char_t item;
        foreach (msg[i])
        begin
            item.char_code = msg[i];
            item.last_char = (i == msg.size() - 1);
            send_char(item);
        end
    endtask

    function automatic logic [7:0] any_lower();
        return 8'($urandom_range(CHR_LOWER_Z, CHR_LOWER_A));
    endfunction

    // Mostly well-formed tokens, with damaged keywords, noise and cut-off endings.
    function automatic byte_q_t build_message();
        byte_q_t    msg;
        string      num_set;
        string      punct_set;
        string      stop_set;
        string      word;
        int         cut;
        int         bad_pos;
        int         variant;
        logic [7:0] ch;
        num_set = "0123456789.-+eE";
        punct_set = ",:{}[]";
        stop_set = ",]}:";
        repeat ($urandom_range(8, 1))
        begin
            case ($urandom_range(9))
                0, 1, 2:
                begin
                    word = kw_words[$urandom_range(2)];
                    variant = $urandom_range(9);
                    cut = (variant == 0) ? $urandom_range(word.len() - 1, 1) : word.len();
                    bad_pos = (variant == 1) ? $urandom_range(word.len() - 1) : -1;
                    for (int i = 0; i < cut; i++)
                        msg.push_back((i == bad_pos) ? any_lower() : word[i]);
                    if (variant == 2)
                    begin
                        repeat ($urandom_range(4, 1))
                            msg.push_back(any_lower());
                    end
                    case ($urandom_range(5))
                        0:       msg.push_back(CHR_QUOTE);
                        1:       msg.push_back(8'($urandom_range(255)));
                        default: msg.push_back(stop_set[$urandom_range(stop_set.len() - 1)]);
                    endcase
                end
                3, 4:
                begin
                    repeat ($urandom_range(6, 1))
                        msg.push_back(num_set[$urandom_range(num_set.len() - 1)]);
                end
                5, 6:
                begin
                    msg.push_back(CHR_QUOTE);
                    repeat ($urandom_range(6))
                    begin
                        if ($urandom_range(4) == 0)
                            msg.push_back(CHR_BSLASH);
                        ch = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                      : 8'($urandom_range(126, 32));
                        msg.push_back(ch);
                    end
                    msg.push_back(CHR_QUOTE);
                end
                7, 8:
                    msg.push_back(punct_set[$urandom_range(punct_set.len() - 1)]);
                default:
                    msg.push_back(8'($urandom_range(255)));
            endcase
        end
        // end some messages mid-token: open word, open string or open escape
        if ($urandom_range(9) == 0)
        begin
            cut = $urandom_range(msg.size(), 1);
            while (msg.size() > cut)
                void'(msg.pop_back());
        end
        return msg;
    endfunction

    task automatic test_directed();
        send_message('{"f", "a", "l", "s", "e", CHR_RBRACK});
        // quote after a word must not open a string, so the bang is caught
        send_message('{"n", "u", "l", "l", "x", CHR_QUOTE, "!"});
        // escaped quote and zero byte in a string, backslash left open at the end
        send_message('{CHR_QUOTE, CHR_BSLASH, CHR_QUOTE, 8'h00, CHR_BSLASH});
        send_message('{8'hFF});
        send_message('{"t", "r", "u", 8'h80});
        send_message('{8'h00, "0", "t"});
        send_message('{"9", "t", "r"});
    endtask

    task automatic test_random_stream(input int idle_pct, input int stall_pct, input int n_items);
        int      sent;
        byte_q_t msg;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items)
        begin
            msg = build_message();
            send_message(msg);
            sent += msg.size();
        end
    endtask

    task automatic test_receiver_hold();
        hold_start = 1'b1;
        test_random_stream(0, 0, 80);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && flag_valid && flag_ready)
        begin
            if (pending_flags.size() == 0)
            begin
                $display("%0t: unexpected flag, expected none, got %b", $time, flag_data);
                flag_mismatches++;
            end
            else
            begin
                if (flag_data.invalid_seen !== pending_flags[0].invalid_seen)
                begin
                    $display("%0t: invalid_seen expected %b got %b", $time,
                             pending_flags[0].invalid_seen, flag_data.invalid_seen);
                    flag_mismatches++;
                end
                if (flag_data.message_done !== pending_flags[0].message_done)
                begin
                    $display("%0t: message_done expected %b got %b", $time,
                             pending_flags[0].message_done, flag_data.message_done);
                    flag_mismatches++;
                end
                void'(pending_flags.pop_front());
            end
        end
        if (hold_start)
        begin
            hold_left = HOLD_CYCLES;
            hold_start = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            flag_ready <= 1'b0;
        end
        else
            flag_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        clear_scanner();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_stream(0, 0, 270);
        test_random_stream(46, 0, 260);
        test_random_stream(0, 46, 260);
        test_random_stream(13, 13, 260);
        test_receiver_hold();
        char_valid <= 1'b0;
        while (pending_flags.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (flag_mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* json_text_prevalidator.f */
hdl/jtp_pkg.sv
hdl/jtp_scan_core.sv
hdl/json_text_prevalidator.sv
tb/json_text_prevalidator_test.sv
